[src/mxs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mxs_pkg
// Shared widths, codes and record types of the mixed-axis step interpolator.
// ----------------------------------------------------------------------------
package mxs_pkg;

  // Longest move component is [-2^DELTA_BITS, 2^DELTA_BITS - 1]
  localparam int DELTA_BITS = 16;
  // Width of the tracked position, wraps modulo 2^POS_BITS
  localparam int POS_BITS   = 32;

  localparam int COORD_W = 32;               // coordinate port width
  localparam int DIFF_W  = COORD_W + 1;      // exact target minus position
  localparam int DLT_W   = DELTA_BITS + 1;   // cartesian delta, signed
  localparam int SUM_W   = DELTA_BITS + 2;   // motor delta, signed
  localparam int CNT_W   = DELTA_BITS + 2;   // motor step counts, unsigned
  localparam int ERR_W   = DELTA_BITS + 3;   // Bresenham error terms, signed

  typedef enum logic [1:0] {
    CMD_REL  = 2'd0,
    CMD_ABS  = 2'd1,
    CMD_TICK = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_DONE  = 2'd1,
    ST_BUSY  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // Decoded move request
  typedef struct packed {
    logic                    ok;
    logic signed [DLT_W-1:0] dx;
    logic signed [DLT_W-1:0] dy;
    logic                    dir_l;
    logic                    dir_r;
    logic [CNT_W-1:0]        count_l;
    logic [CNT_W-1:0]        count_r;
    logic [CNT_W-1:0]        count_max;
  } move_plan_t;

  // Outcome of one interpolation tick
  typedef struct packed {
    logic                    step_l;
    logic                    step_r;
    logic signed [ERR_W-1:0] err_l;
    logic signed [ERR_W-1:0] err_r;
    logic                    done;
  } tick_res_t;

endpackage

[src/mxs_move_plan.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mxs_move_plan
// Turns a relative or absolute move request into cartesian and motor deltas.
// ----------------------------------------------------------------------------
module mxs_move_plan (
  input  logic                                   is_abs,
  input  logic signed [mxs_pkg::COORD_W-1:0]     coord_x,
  input  logic signed [mxs_pkg::COORD_W-1:0]     coord_y,
  input  logic signed [mxs_pkg::POS_BITS-1:0]    pos_x,
  input  logic signed [mxs_pkg::POS_BITS-1:0]    pos_y,
  output mxs_pkg::move_plan_t                    plan
);

  logic signed [mxs_pkg::DIFF_W-1:0] diff_x;
  logic signed [mxs_pkg::DIFF_W-1:0] diff_y;
  logic                              ok_x;
  logic                              ok_y;
  logic signed [mxs_pkg::DLT_W-1:0]  dx;
  logic signed [mxs_pkg::DLT_W-1:0]  dy;
  logic signed [mxs_pkg::SUM_W-1:0]  sum_l;
  logic signed [mxs_pkg::SUM_W-1:0]  sum_r;
  logic        [mxs_pkg::CNT_W-1:0]  cnt_l;
  logic        [mxs_pkg::CNT_W-1:0]  cnt_r;

  always_comb begin
    if (is_abs) begin
      diff_x = mxs_pkg::DIFF_W'(coord_x) - mxs_pkg::DIFF_W'(pos_x);
      diff_y = mxs_pkg::DIFF_W'(coord_y) - mxs_pkg::DIFF_W'(pos_y);
    end else begin
      diff_x = mxs_pkg::DIFF_W'(coord_x);
      diff_y = mxs_pkg::DIFF_W'(coord_y);
    end
  end

  // In range when every bit from DELTA_BITS upward matches the sign
  assign ok_x = (&diff_x[mxs_pkg::DIFF_W-1:mxs_pkg::DELTA_BITS]) ||
                !(|diff_x[mxs_pkg::DIFF_W-1:mxs_pkg::DELTA_BITS]);
  assign ok_y = (&diff_y[mxs_pkg::DIFF_W-1:mxs_pkg::DELTA_BITS]) ||
                !(|diff_y[mxs_pkg::DIFF_W-1:mxs_pkg::DELTA_BITS]);

  assign dx = diff_x[mxs_pkg::DLT_W-1:0];
  assign dy = diff_y[mxs_pkg::DLT_W-1:0];

  assign sum_l = mxs_pkg::SUM_W'(dx) + mxs_pkg::SUM_W'(dy);
  assign sum_r = mxs_pkg::SUM_W'(dx) - mxs_pkg::SUM_W'(dy);

  assign cnt_l = sum_l[mxs_pkg::SUM_W-1] ? -sum_l : sum_l;
  assign cnt_r = sum_r[mxs_pkg::SUM_W-1] ? -sum_r : sum_r;

  always_comb begin
    plan.ok        = ok_x && ok_y;
    plan.dx        = dx;
    plan.dy        = dy;
    plan.dir_l     = !sum_l[mxs_pkg::SUM_W-1] && (sum_l != '0);
    plan.dir_r     = !sum_r[mxs_pkg::SUM_W-1] && (sum_r != '0);
    plan.count_l   = cnt_l;
    plan.count_r   = cnt_r;
    plan.count_max = (cnt_l > cnt_r) ? cnt_l : cnt_r;
  end

endmodule

[src/mxs_tick.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mxs_tick
// One Bresenham iteration for both motors on the registered error terms.
// ----------------------------------------------------------------------------
module mxs_tick (
  input  logic        [mxs_pkg::CNT_W-1:0]  count_l,
  input  logic        [mxs_pkg::CNT_W-1:0]  count_r,
  input  logic        [mxs_pkg::CNT_W-1:0]  count_max,
  input  logic        [mxs_pkg::CNT_W-1:0]  ticks_left,
  input  logic signed [mxs_pkg::ERR_W-1:0]  err_l,
  input  logic signed [mxs_pkg::ERR_W-1:0]  err_r,
  output mxs_pkg::tick_res_t                res
);

  logic signed [mxs_pkg::ERR_W-1:0] cl_s;
  logic signed [mxs_pkg::ERR_W-1:0] cr_s;
  logic signed [mxs_pkg::ERR_W-1:0] cm_s;
  logic                             ge_l;
  logic                             ge_r;

  // counts are unsigned, so widen with zeros
  assign cl_s = mxs_pkg::ERR_W'(count_l);
  assign cr_s = mxs_pkg::ERR_W'(count_r);
  assign cm_s = mxs_pkg::ERR_W'(count_max);

  assign ge_l = err_l >= cl_s;
  assign ge_r = err_r >= cr_s;

  always_comb begin
    res.step_l = ge_l && (count_l != '0);
    res.step_r = ge_r && (count_r != '0);
    res.err_l  = (ge_l ? err_l - cm_s : err_l) + cl_s;
    res.err_r  = (ge_r ? err_r - cm_s : err_r) + cr_s;
    res.done   = ticks_left <= mxs_pkg::CNT_W'(1);
  end

endmodule

[src/mixed_axis_step_interpolator_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mixed_axis_step_interpolator_top
// Two-motor Bresenham step interpolator for an H-bot style plotter.
// ----------------------------------------------------------------------------
// Each request is a relative move, an absolute move or one interpolation
// tick. A move is mapped to motor deltas left = dx+dy and right = dx-dy and
// then driven out by tick requests, one Bresenham iteration per tick, over
// max(|left|,|right|) ticks; the tracked position advances on the last tick.
// Moves given while a move runs are refused with the busy status, moves whose
// delta exceeds the DELTA_BITS range are refused with the range status.
// Throughput is one request per clock unless the response side stalls: all
// of the work for a request is one pass of combinational logic (move decode
// or one compare/subtract/add per motor) between the request register and
// the response register, and the state it updates is ready for the next
// request in the following cycle. A request passes the request register and
// then the response register, which decouples the two sides: requests keep
// flowing while a response waits, and a stall backs up only once both hold.
// ----------------------------------------------------------------------------
module mixed_axis_step_interpolator_top (
  input  logic                                 clk,
  input  logic                                 rst,
  // request channel
  input  logic                                 cmd_valid,
  output logic                                 cmd_stall,
  input  logic [1:0]                           cmd,
  input  logic signed [mxs_pkg::COORD_W-1:0]   coord_x,
  input  logic signed [mxs_pkg::COORD_W-1:0]   coord_y,
  // response channel
  output logic                                 res_valid,
  input  logic                                 res_stall,
  output logic                                 step_left,
  output logic                                 step_right,
  output logic                                 dir_left,
  output logic                                 dir_right,
  output logic                                 busy_res,
  output logic [1:0]                           status,
  output logic signed [mxs_pkg::COORD_W-1:0]   pos_x_out,
  output logic signed [mxs_pkg::COORD_W-1:0]   pos_y_out
);

  // request register
  logic                                in_v;
  logic [1:0]                          in_cmd;
  logic signed [mxs_pkg::COORD_W-1:0]  in_cx;
  logic signed [mxs_pkg::COORD_W-1:0]  in_cy;

  // interpolator state
  logic signed [mxs_pkg::POS_BITS-1:0] pos_x, pos_x_next;
  logic signed [mxs_pkg::POS_BITS-1:0] pos_y, pos_y_next;
  logic signed [mxs_pkg::DLT_W-1:0]    pending_dx, pending_dx_next;
  logic signed [mxs_pkg::DLT_W-1:0]    pending_dy, pending_dy_next;
  logic [mxs_pkg::CNT_W-1:0]           count_left, count_left_next;
  logic [mxs_pkg::CNT_W-1:0]           count_right, count_right_next;
  logic [mxs_pkg::CNT_W-1:0]           count_max, count_max_next;
  logic signed [mxs_pkg::ERR_W-1:0]    err_left, err_left_next;
  logic signed [mxs_pkg::ERR_W-1:0]    err_right, err_right_next;
  logic [mxs_pkg::CNT_W-1:0]           ticks_left, ticks_left_next;
  logic                                dir_left_reg, dir_left_reg_next;
  logic                                dir_right_reg, dir_right_reg_next;
  logic                                moving, moving_next;

  logic                                res_free;
  logic                                fire;
  logic                                sl, sr;
  mxs_pkg::status_t                    st;
  mxs_pkg::move_plan_t                 plan;
  mxs_pkg::tick_res_t                  tick;
  logic signed [mxs_pkg::ERR_W-1:0]    half_max;

  // response register can take a new entry when empty or being drained
  assign res_free  = !res_valid || !res_stall;
  assign fire      = in_v && res_free;
  assign cmd_stall = in_v && !res_free;

  mxs_move_plan u_plan (
    .is_abs  (in_cmd == mxs_pkg::CMD_ABS),
    .coord_x (in_cx),
    .coord_y (in_cy),
    .pos_x   (pos_x),
    .pos_y   (pos_y),
    .plan    (plan)
  );

  mxs_tick u_tick (
    .count_l    (count_left),
    .count_r    (count_right),
    .count_max  (count_max),
    .ticks_left (ticks_left),
    .err_l      (err_left),
    .err_r      (err_right),
    .res        (tick)
  );

  // both error terms start at half the longer count, rounded down
  assign half_max = mxs_pkg::ERR_W'(plan.count_max >> 1);

  always_comb begin
    pos_x_next         = pos_x;
    pos_y_next         = pos_y;
    pending_dx_next    = pending_dx;
    pending_dy_next    = pending_dy;
    count_left_next    = count_left;
    count_right_next   = count_right;
    count_max_next     = count_max;
    err_left_next      = err_left;
    err_right_next     = err_right;
    ticks_left_next    = ticks_left;
    dir_left_reg_next  = dir_left_reg;
    dir_right_reg_next = dir_right_reg;
    moving_next        = moving;
    sl                 = 1'b0;
    sr                 = 1'b0;
    st                 = mxs_pkg::ST_OK;

    if (fire) begin
      case (in_cmd)
        mxs_pkg::CMD_REL, mxs_pkg::CMD_ABS: begin
          if (moving) begin
            st = mxs_pkg::ST_BUSY;
          end else if (!plan.ok) begin
            st = mxs_pkg::ST_RANGE;
          end else begin
            pending_dx_next    = plan.dx;
            pending_dy_next    = plan.dy;
            dir_left_reg_next  = plan.dir_l;
            dir_right_reg_next = plan.dir_r;
            count_left_next    = plan.count_l;
            count_right_next   = plan.count_r;
            count_max_next     = plan.count_max;
            err_left_next      = half_max;
            err_right_next     = half_max;
            ticks_left_next    = plan.count_max;
            // zero-length move finishes at once, position unchanged
            if (plan.count_max == '0) begin
              moving_next = 1'b0;
              st          = mxs_pkg::ST_DONE;
            end else begin
              moving_next = 1'b1;
            end
          end
        end
        mxs_pkg::CMD_TICK: begin
          if (moving) begin
            sl              = tick.step_l;
            sr              = tick.step_r;
            err_left_next   = tick.err_l;
            err_right_next  = tick.err_r;
            ticks_left_next = ticks_left - mxs_pkg::CNT_W'(1);
            if (tick.done) begin
              ticks_left_next = '0;
              moving_next     = 1'b0;
              pos_x_next      = pos_x + mxs_pkg::POS_BITS'(pending_dx);
              pos_y_next      = pos_y + mxs_pkg::POS_BITS'(pending_dy);
              st              = mxs_pkg::ST_DONE;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // request register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (!cmd_stall) begin
      in_v <= cmd_valid;
    end
    if (cmd_valid && !cmd_stall) begin
      in_cmd <= cmd;
      in_cx  <= coord_x;
      in_cy  <= coord_y;
    end
  end

  // interpolator state
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x         <= '0;
      pos_y         <= '0;
      pending_dx    <= '0;
      pending_dy    <= '0;
      count_left    <= '0;
      count_right   <= '0;
      count_max     <= '0;
      err_left      <= '0;
      err_right     <= '0;
      ticks_left    <= '0;
      dir_left_reg  <= 1'b0;
      dir_right_reg <= 1'b0;
      moving        <= 1'b0;
    end else begin
      pos_x         <= pos_x_next;
      pos_y         <= pos_y_next;
      pending_dx    <= pending_dx_next;
      pending_dy    <= pending_dy_next;
      count_left    <= count_left_next;
      count_right   <= count_right_next;
      count_max     <= count_max_next;
      err_left      <= err_left_next;
      err_right     <= err_right_next;
      ticks_left    <= ticks_left_next;
      dir_left_reg  <= dir_left_reg_next;
      dir_right_reg <= dir_right_reg_next;
      moving        <= moving_next;
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_free) begin
      res_valid <= in_v;
    end
    if (fire) begin
      step_left  <= sl;
      step_right <= sr;
      dir_left   <= dir_left_reg_next;
      dir_right  <= dir_right_reg_next;
      busy_res   <= moving_next;
      status     <= st;
      pos_x_out  <= mxs_pkg::COORD_W'(pos_x_next);
      pos_y_out  <= mxs_pkg::COORD_W'(pos_y_next);
    end
  end

endmodule
